[rtl/u8d_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int BITS_W      = 7;
    localparam int CONT_BITS   = 6;
    localparam int OUT_DATA_W  = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
    localparam logic [BYTE_W-1:0] CODE_LEAD2 = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
    localparam logic [BYTE_W-1:0] CODE_LEAD3 = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
    localparam logic [BYTE_W-1:0] CODE_LEAD4 = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
    localparam logic [BYTE_W-1:0] CODE_CONT  = 8'h80;

    typedef enum logic [2:0] {
        K_ASCII,
        K_LEAD2,
        K_LEAD3,
        K_LEAD4,
        K_CONT,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BITS_W-1:0] bits;
        logic              eos;
    } t_item;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            error;
        logic            stream_done;
    } t_result;

endpackage
`default_nettype wire

[rtl/u8d_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_front
// Classifies each input byte as ASCII, lead, continuation or invalid and
// extracts its payload bits.
// ----------------------------------------------------------------------------
module u8d_front (
    input  wire logic [u8d_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                       i_eos,
    output u8d_pkg::t_item                  o_item
);
    import u8d_pkg::*;

    always_comb begin
        o_item.eos  = i_eos;
        o_item.bits = '0;
        if (i_byte <= ASCII_MAX) begin
            o_item.kind = K_ASCII;
            o_item.bits = i_byte[BITS_W-1:0];
        end else if ((i_byte & MASK_CONT) == CODE_CONT) begin
            o_item.kind = K_CONT;
            o_item.bits = {1'b0, i_byte[5:0]};
        end else if ((i_byte & MASK_LEAD2) == CODE_LEAD2) begin
            o_item.kind = K_LEAD2;
            o_item.bits = {2'b0, i_byte[4:0]};
        end else if ((i_byte & MASK_LEAD3) == CODE_LEAD3) begin
            o_item.kind = K_LEAD3;
            o_item.bits = {3'b0, i_byte[3:0]};
        end else if ((i_byte & MASK_LEAD4) == CODE_LEAD4) begin
            o_item.kind = K_LEAD4;
            o_item.bits = {4'b0, i_byte[2:0]};
        end else begin
            o_item.kind = K_BAD;
        end
    end

endmodule
`default_nettype wire

[rtl/u8d_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_queue
// Short queue of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module u8d_queue (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire u8d_pkg::t_item i_item,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_valid,
    output u8d_pkg::t_item o_item
);
    import u8d_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] q;
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");
`endif

endmodule
`default_nettype wire

[rtl/u8d_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_back
// Sequence state and code point assembly, with a registered result stage.
// ----------------------------------------------------------------------------
module u8d_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire u8d_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_res_valid,
    output u8d_pkg::t_result o_res,
    input  wire logic       i_res_ready
);
    import u8d_pkg::*;

    logic [1:0]      r_pend;
    logic [CP_W-1:0] r_part;
    logic            r_out_valid;
    t_result         r_out;

    logic [1:0]      n_pend;
    logic [CP_W-1:0] n_part;
    logic            n_emit;
    t_result         n_res;
    logic            w_fire;
    logic [CP_W-1:0] w_shifted;
    logic [1:0]      w_pend_dec;

    assign o_ready     = !r_out_valid || i_res_ready;
    assign w_fire      = i_valid && o_ready;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign w_shifted   = {r_part[CP_W-CONT_BITS-1:0], i_item.bits[CONT_BITS-1:0]};
    assign w_pend_dec  = r_pend - 1'b1;

    always_comb begin
        n_pend            = r_pend;
        n_part            = r_part;
        n_emit            = 1'b0;
        n_res.code_point  = '0;
        n_res.error       = 1'b1;
        n_res.stream_done = i_item.eos;
        if (r_pend == 2'd0) begin
            case (i_item.kind)
                K_ASCII: begin
                    n_emit           = 1'b1;
                    n_res.code_point = CP_W'(i_item.bits);
                    n_res.error      = 1'b0;
                end
                K_LEAD2, K_LEAD3, K_LEAD4: begin
                    if (i_item.eos) begin
                        n_emit = 1'b1;
                    end else begin
                        n_part = CP_W'(i_item.bits);
                        if (i_item.kind == K_LEAD2) begin
                            n_pend = 2'd1;
                        end else if (i_item.kind == K_LEAD3) begin
                            n_pend = 2'd2;
                        end else begin
                            n_pend = 2'd3;
                        end
                    end
                end
                default: begin
                    n_emit = 1'b1;
                end
            endcase
        end else if (i_item.kind != K_CONT) begin
            n_emit = 1'b1;
            n_pend = 2'd0;
            n_part = '0;
        end else if (w_pend_dec == 2'd0) begin
            n_emit           = 1'b1;
            n_res.code_point = w_shifted;
            n_res.error      = 1'b0;
            n_pend           = 2'd0;
            n_part           = '0;
        end else if (i_item.eos) begin
            n_emit = 1'b1;
            n_pend = 2'd0;
            n_part = '0;
        end else begin
            n_pend = w_pend_dec;
            n_part = w_shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && n_emit) begin
            r_out <= n_res;
        end
        if (!i_rst_n) begin
            r_pend      <= 2'd0;
            r_part      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_pend <= n_pend;
                r_part <= n_part;
            end
            if (o_ready) begin
                r_out_valid <= w_fire && n_emit;
            end
        end
    end

`ifndef ASSERT_OFF
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd0) |-> (r_part == '0))
        else $error("partial code point left over while idle");
    a_part_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pend == 2'd3) |-> (r_part[CP_W-1:3] == '0)) and
        ((r_pend == 2'd2) |-> (r_part[CP_W-1:9] == '0)) and
        ((r_pend == 2'd1) |-> (r_part[CP_W-1:15] == '0)))
        else $error("partial code point wider than the open sequence allows");
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error) |-> (r_out.code_point == '0))
        else $error("error result carries a code point");
    a_break_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_pend != 2'd0) && (i_item.kind != K_CONT)) |=> (r_pend == 2'd0))
        else $error("broken sequence did not return to idle");
`endif

endmodule
`default_nettype wire

[rtl/utf8_stream_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder with a classifying front, a short queue and a
// decoding back part.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on the s_axis channel, one per beat: tdata carries the byte and
// tlast marks the last byte of a stream. Results leave on the m_axis channel:
// tdata carries the 21-bit code point, tuser flags an error (bad lead byte,
// missing continuation byte or a sequence cut short by the end of the stream)
// and tlast repeats the end-of-stream mark of the byte that caused the result.
// Lead bytes that open a sequence and inner continuation bytes give no beat;
// every byte marked with tlast gives exactly one beat. Overlong forms and
// surrogates are passed on. Throughput is one byte per cycle while the receiver
// does not stall, set by the decode step in the back part. Each accepted byte is
// queued, and once the back part takes it, its result is registered for m_axis.
// A two-entry queue sits between the byte classifier and the decoder, so
// s_axis_tready stays high until that queue fills; when the receiver stalls,
// the registered result holds and the queue absorbs up to two more bytes.
// A synchronous active-low reset empties the queue, drops any pending result
// and returns the decoder to idle with no partial sequence.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [u8d_pkg::BYTE_W-1:0]     s_axis_tdata,  // [7:0] byte_value
    input  wire logic                           s_axis_tlast,  // end_of_stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [u8d_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [20:0] code_point
    output logic                                m_axis_tuser,  // error
    output logic                                m_axis_tlast   // stream_done
);
    import u8d_pkg::*;

    t_item   w_front_item;
    t_item   w_queue_item;
    logic    w_queue_full;
    logic    w_queue_valid;
    logic    w_back_ready;
    t_result w_res;

    assign s_axis_tready = !w_queue_full;

    u8d_front u_front (
        .i_byte (s_axis_tdata),
        .i_eos  (s_axis_tlast),
        .o_item (w_front_item)
    );

    u8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (w_front_item),
        .o_full  (w_queue_full),
        .i_pop   (w_back_ready),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item)
    );

    u8d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_queue_valid),
        .i_item      (w_queue_item),
        .o_ready     (w_back_ready),
        .o_res_valid (m_axis_tvalid),
        .o_res       (w_res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - CP_W){1'b0}}, w_res.code_point};
    assign m_axis_tuser = w_res.error;
    assign m_axis_tlast = w_res.stream_done;

endmodule
`default_nettype wire
